FILE: rtl/pis_pkg.sv
// Shared constants for the Poisson inversion sampler.
// Used by pis_div and poisson_inversion_sampler; depends on nothing.
package pis_pkg;

   // Search cap on the event count
   localparam int MAX_COUNT = 255;

   // Field widths
   localparam int U_W      = 32;   // uniform word, Q0.32
   localparam int LAMBDA_W = 32;   // rate, Q8.24
   localparam int PROB_W   = 33;   // probability terms, Q1.32
   localparam int OUT_W    = 8;    // event_count port
   localparam int PROD_W   = 64;   // lambda * p, p low half only
   localparam int FRAC_SH  = 24;   // lambda fraction bits
   localparam int DIVD_W   = PROD_W - FRAC_SH;

   // Count register: at least as wide as the output port
   localparam int CNT_RAW_W = $clog2(MAX_COUNT + 1);
   localparam int CNT_W     = (CNT_RAW_W > OUT_W) ? CNT_RAW_W : OUT_W;

   // Divider step counter
   localparam int STEP_W = $clog2(DIVD_W);

   // Constants
   localparam logic [PROB_W-1:0]   PROB_ONE     = {1'b1, {(PROB_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]    COUNT_MAX    = CNT_W'(MAX_COUNT);
   localparam logic [CNT_W-1:0]    COUNT_SAT    = CNT_W'((1 << OUT_W) - 1);
   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 32'd16777216;
   localparam logic [PROB_W-1:0]   PROB_RESET   = 33'd1580030169;

   // Register index codes (paddr bit 3)
   localparam logic REG_LAMBDA = 1'b0;
   localparam logic REG_PROB   = 1'b1;

endpackage

FILE: rtl/poisson_inversion_sampler.sv
// Poisson variate sampler by sequential inversion: sequencer, multiplier, accumulator, CSRs.
// Depends on pis_pkg and pis_div.
//
//  channel   ports                                   flow
//  -------   -------------------------------------   ---------------------------------
//  input     start, busy, req_uniform_word           taken when start && !busy
//  result    rsp_valid, rsp_event_count, rsp_limit_hit  one-cycle strobe, no backpressure
//  config    csr_psel/penable/pwrite/paddr/pwdata/   APB, 64-bit data, regs at 0x0, 0x8
//            prdata/pready
//
// Each count step costs a compare, a 32x32 multiply, a divider start, a wait on the
// bit-serial divider (40 quotient bits, then its done strobe) and an update. busy is
// high from the accepted beat until the result strobe; the strobe cycle already
// accepts the next beat.
// Synchronous active-high reset restores the registers to lambda = 1.0, p0 = e^-1.
module poisson_inversion_sampler (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        start,
   output logic                        busy,
   input  logic [pis_pkg::U_W-1:0]     req_uniform_word,
   // result channel
   output logic                        rsp_valid,
   output logic [pis_pkg::OUT_W-1:0]   rsp_event_count,
   output logic                        rsp_limit_hit,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [pis_pkg::LAMBDA_W-1:0]   lambda_ff, lambda_in;
   logic [pis_pkg::PROB_W-1:0]     pstart_ff, pstart_in;
   logic [pis_pkg::U_W-1:0]        u_ff, u_in;
   logic [pis_pkg::PROB_W-1:0]     p_ff, p_in;
   logic [pis_pkg::PROB_W-1:0]     acc_ff, acc_in;
   logic [pis_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [pis_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pis_pkg::OUT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                           rsp_limit_ff, rsp_limit_in;

   logic                           csr_write;
   logic                           accept;
   logic                           div_start;
   logic                           div_done;
   logic [pis_pkg::DIVD_W-1:0]     div_quotient;
   logic [pis_pkg::PROB_W-1:0]     p_start_clamped;
   logic [pis_pkg::PROB_W-1:0]     p_next;
   logic [pis_pkg::PROB_W:0]       acc_sum;
   logic                           search_on;
   logic [pis_pkg::OUT_W-1:0]      count_sat;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign accept    = start && !busy;
   assign div_start = (state_ff == ST_DIV);

   // Divider for the p update
   pis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[pis_pkg::PROD_W-1:pis_pkg::FRAC_SH]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Clamps and accumulate
   always_comb begin
      p_start_clamped = (pstart_ff > pis_pkg::PROB_ONE) ? pis_pkg::PROB_ONE : pstart_ff;
      p_next = (div_quotient > pis_pkg::DIVD_W'(pis_pkg::PROB_ONE))
               ? pis_pkg::PROB_ONE : div_quotient[pis_pkg::PROB_W-1:0];
      acc_sum   = {1'b0, acc_ff} + {1'b0, p_next};
      search_on = ({1'b0, u_ff} > acc_ff);
      count_sat = (count_ff > pis_pkg::COUNT_SAT) ? pis_pkg::COUNT_SAT[pis_pkg::OUT_W-1:0]
                                                  : count_ff[pis_pkg::OUT_W-1:0];
   end

   // Register writes
   always_comb begin
      lambda_in = lambda_ff;
      pstart_in = pstart_ff;
      if (csr_write) begin
         case (csr_paddr[3])
            pis_pkg::REG_LAMBDA: lambda_in = csr_pwdata[pis_pkg::LAMBDA_W-1:0];
            pis_pkg::REG_PROB:   pstart_in = csr_pwdata[pis_pkg::PROB_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_limit_in = rsp_limit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               u_in     = req_uniform_word;
               p_in     = p_start_clamped;
               acc_in   = p_start_clamped;
               count_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (search_on && count_ff < pis_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_sat;
               rsp_limit_in = search_on;
               state_in     = ST_IDLE;
            end
         end
         ST_MUL: begin
            // p is at most 1.0, so a set top bit means the low half is zero
            prod_in  = p_ff[pis_pkg::PROB_W-1] ? {lambda_ff, 32'd0}
                                               : lambda_ff * p_ff[pis_pkg::PROB_W-2:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            p_in     = p_next;
            acc_in   = (acc_sum > {1'b0, pis_pkg::PROB_ONE}) ? pis_pkg::PROB_ONE
                                                            : acc_sum[pis_pkg::PROB_W-1:0];
            state_in = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lambda_ff    <= pis_pkg::LAMBDA_RESET;
         pstart_ff    <= pis_pkg::PROB_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lambda_ff    <= lambda_in;
         pstart_ff    <= pstart_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      u_ff         <= u_in;
      p_ff         <= p_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   // Ports
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_count = rsp_count_ff;
   assign rsp_limit_hit   = rsp_limit_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr[3] == pis_pkg::REG_PROB)
                            ? {{(64-pis_pkg::PROB_W){1'b0}}, pstart_ff}
                            : {{(64-pis_pkg::LAMBDA_W){1'b0}}, lambda_ff};

   // Checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted beat did not start search");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      busy |-> count_ff <= pis_pkg::COUNT_MAX) else $error("count above cap");
   a_acc_sat: assert property (@(posedge clock) disable iff (reset)
      busy |-> acc_ff <= pis_pkg::PROB_ONE) else $error("accumulator above one");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_WAIT) else $error("divider done outside wait");

endmodule

FILE: rtl/pis_div.sv
// Restoring divider, one quotient bit per cycle, for the sampler's p update.
// Depends on pis_pkg for widths.
module pis_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pis_pkg::DIVD_W-1:0]  dividend,
   input  logic [pis_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [pis_pkg::DIVD_W-1:0]  quotient
);

   localparam logic [pis_pkg::STEP_W-1:0] LastStep = pis_pkg::STEP_W'(pis_pkg::DIVD_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [pis_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [pis_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [pis_pkg::DIVD_W-1:0]   quo_ff, quo_in;
   logic [pis_pkg::CNT_W-1:0]    dsr_ff, dsr_in;
   logic [pis_pkg::CNT_W:0]      shifted;
   logic [pis_pkg::CNT_W:0]      diff;
   logic                         fits;

   // One step: shift in next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[pis_pkg::DIVD_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
   end

   // Next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[pis_pkg::CNT_W-1:0] : shifted[pis_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[pis_pkg::DIVD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Checks
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without run");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && dsr_ff != '0 |-> rem_ff < dsr_ff) else $error("remainder not reduced");

endmodule
